[rtl/gimbal_angle_to_servo_pulse_macros.svh]
// Assertion macros for the gimbal angle to servo pulse block.
// Used by the top level; no other dependencies.
`ifndef GIMBAL_ANGLE_TO_SERVO_PULSE_MACROS_SVH
`define GIMBAL_ANGLE_TO_SERVO_PULSE_MACROS_SVH

// combinational or sequence property under clock and reset
`define GASP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// cond holds, then prop holds in the next cycle
`define GASP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/gasp_pkg.sv]
// Shared types and constants for the gimbal angle to servo pulse block.
// No dependencies.
package gasp_pkg;

   localparam int PULSE_MAX_DEFAULT = 19999;

   localparam int ANGLE_W = 16;
   localparam int PULSE_W = 15;
   localparam int QUOT_W  = 15;
   localparam int PROD_W  = 2 * QUOT_W;

   localparam int DIV_STEPS   = 3;
   localparam int DIV_STAGES  = QUOT_W / DIV_STEPS;
   localparam int PIPE_STAGES = DIV_STAGES + 3;

   typedef enum logic [2:0] {
      CSR_YAW_LIMIT        = 3'd0,
      CSR_PITCH_LIMIT      = 3'd1,
      CSR_REVERSE_FLAGS    = 3'd2,
      CSR_YAW_PULSE_MIN    = 3'd3,
      CSR_YAW_PULSE_CENTER = 3'd4,
      CSR_YAW_PULSE_MAX    = 3'd5,
      CSR_PITCH_PULSE_MIN  = 3'd6,
      CSR_PITCH_PULSE_MAX  = 3'd7
   } csr_index_type;

endpackage

[rtl/gasp_div_pipe.sv]
// Pipelined restoring divider: 30 bit dividend by 15 bit divisor, quotient
// known to fit 15 bits. Depends on gasp_pkg.
module gasp_div_pipe (
   input  logic                             clock,
   input  logic [gasp_pkg::DIV_STAGES-1:0]  stage_en,
   input  logic [gasp_pkg::PROD_W-1:0]      dividend,
   input  logic                             neg_in,
   input  logic [gasp_pkg::QUOT_W-1:0]      divisor,
   output logic [gasp_pkg::QUOT_W-1:0]      quotient,
   output logic                             neg_out
);
   import gasp_pkg::*;

   // acc holds {partial remainder, remaining dividend bits / quotient bits}
   logic [PROD_W-1:0] acc_ff [DIV_STAGES];
   logic [PROD_W-1:0] acc_in [DIV_STAGES];
   logic              neg_ff [DIV_STAGES];

   function automatic logic [PROD_W-1:0] div_steps(input logic [PROD_W-1:0] acc,
                                                   input logic [QUOT_W-1:0] d);
      logic [PROD_W-1:0] a;
      logic [QUOT_W:0]   t;
      logic [QUOT_W:0]   r;
      int                s;
      a = acc;
      for (s = 0; s < DIV_STEPS; s++) begin
         t = a[PROD_W-1:QUOT_W-1];
         r = t - {1'b0, d};
         if (t >= {1'b0, d}) begin
            a = {r[QUOT_W-1:0], a[QUOT_W-2:0], 1'b1};
         end else begin
            a = {t[QUOT_W-1:0], a[QUOT_W-2:0], 1'b0};
         end
      end
      return a;
   endfunction

   always_comb begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (i == 0) begin
            acc_in[i] = div_steps(dividend, divisor);
         end else begin
            acc_in[i] = div_steps(acc_ff[i-1], divisor);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (stage_en[i]) begin
            acc_ff[i] <= acc_in[i];
            neg_ff[i] <= (i == 0) ? neg_in : neg_ff[i-1];
         end
      end
   end

   assign quotient = acc_ff[DIV_STAGES-1][QUOT_W-1:0];
   assign neg_out  = neg_ff[DIV_STAGES-1];

endmodule

[rtl/gimbal_angle_to_servo_pulse.sv]
// Gimbal angle to servo pulse converter, top level.
// Depends on gasp_pkg, gasp_div_pipe and gimbal_angle_to_servo_pulse_macros.svh.
//
// Usage:
//   req_* takes one word per angle pair: yaw and pitch in signed hundredths
//   of a degree. rsp_* returns one word per request with the two servo
//   compare values, saturated to 0..PULSE_MAX.
//   csr_* writes the limit, reverse and pulse registers by index; write only
//   while no request is in flight. csr_ready is always high.
// Pipeline: an accepted request passes clamp, multiply, five divider stages
//   of three quotient bits each, and the output register.
// Throughput: one word per cycle while rsp_tready is high; the pipeline holds up to 8 words.
// Stall: each stage advances when it is empty or the next one advances, so
//   bubbles fill while the output waits; req_tready drops only when every
//   stage is full and rsp_tready is low.
// Reset: clears all stage valid bits and loads the register defaults.
module gimbal_angle_to_servo_pulse #(
   parameter int PULSE_MAX = gasp_pkg::PULSE_MAX_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,   // yaw_angle[15:0], pitch_angle[31:16]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,   // yaw_pulse[14:0], pitch_pulse[29:15], zero
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  gasp_pkg::csr_index_type csr_index,
   input  logic [14:0]             csr_data
);
   import gasp_pkg::*;

   `include "gimbal_angle_to_servo_pulse_macros.svh"

   localparam int S_OUT = PIPE_STAGES - 1;
   localparam logic signed [17:0] PULSE_MAX_S = 18'(PULSE_MAX);

   // registers
   logic [14:0] ylim_ff, plim_ff, ymin_ff, ycen_ff, ymax_ff, pmin_ff, pmax_ff;
   logic [1:0]  rev_ff;

   // pipeline control
   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] en;

   // stage 0: clamped magnitudes
   logic [QUOT_W-1:0] yang_ff, yspan_ff, pang_ff, pspan_ff;
   logic              yneg0_ff, pneg0_ff;
   logic [QUOT_W-1:0] yang_in, yspan_in, pang_in, pspan_in;
   logic              yneg0_in, pneg0_in;

   // stage 1: products
   logic [PROD_W-1:0] yprod_ff, pprod_ff;
   logic              yneg1_ff, pneg1_ff;

   // divider outputs
   logic [QUOT_W-1:0] yquot, pquot, ydiv, pdiv;
   logic              yneg2, pneg2;

   // output stage
   logic [PULSE_W-1:0] ypulse_ff, ppulse_ff, ypulse_in, ppulse_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ylim_ff <= 15'd18000;
         plim_ff <= 15'd9000;
         rev_ff  <= 2'd0;
         ymin_ff <= 15'd1000;
         ycen_ff <= 15'd1500;
         ymax_ff <= 15'd2000;
         pmin_ff <= 15'd1000;
         pmax_ff <= 15'd2000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_YAW_LIMIT:        ylim_ff <= csr_data;
            CSR_PITCH_LIMIT:      plim_ff <= csr_data;
            CSR_REVERSE_FLAGS:    rev_ff  <= csr_data[1:0];
            CSR_YAW_PULSE_MIN:    ymin_ff <= csr_data;
            CSR_YAW_PULSE_CENTER: ycen_ff <= csr_data;
            CSR_YAW_PULSE_MAX:    ymax_ff <= csr_data;
            CSR_PITCH_PULSE_MIN:  pmin_ff <= csr_data;
            CSR_PITCH_PULSE_MAX:  pmax_ff <= csr_data;
         endcase
      end
   end

   // stage enables
   always_comb begin
      en[S_OUT] = !valid_ff[S_OUT] || rsp_tready;
      for (int i = S_OUT - 1; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < PIPE_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= (i == 0) ? req_tvalid : valid_ff[i-1];
            end
         end
      end
   end

   // stage 0: clamp, reverse, span select, magnitudes and signs
   always_comb begin
      logic signed [16:0] yaw_s, pit_s, ylim_s, plim_s, ycl, pcl, ysp, psp, yabs, pabs;
      yaw_s  = {req_tdata[15], req_tdata[15:0]};
      pit_s  = {req_tdata[31], req_tdata[31:16]};
      ylim_s = {2'b00, ylim_ff};
      plim_s = {2'b00, plim_ff};
      ycl = yaw_s;
      if (yaw_s > ylim_s) begin
         ycl = ylim_s;
      end else if (yaw_s < -ylim_s) begin
         ycl = -ylim_s;
      end
      if (rev_ff[0]) begin
         ycl = -ycl;
      end
      if (ycl > 17'sd0) begin
         ysp = $signed({2'b00, ymax_ff}) - $signed({2'b00, ycen_ff});
      end else begin
         ysp = $signed({2'b00, ycen_ff}) - $signed({2'b00, ymin_ff});
      end
      pcl = pit_s;
      if (pit_s < 17'sd0) begin
         pcl = 17'sd0;
      end else if (pit_s > plim_s) begin
         pcl = plim_s;
      end
      psp  = $signed({2'b00, pmax_ff}) - $signed({2'b00, pmin_ff});
      yabs = ycl[16] ? -ycl : ycl;
      pabs = psp[16] ? -psp : psp;
      yang_in  = yabs[QUOT_W-1:0];
      yspan_in = ysp[16] ? 15'(-ysp) : ysp[QUOT_W-1:0];
      yneg0_in = ycl[16] ^ ysp[16];
      pang_in  = pcl[QUOT_W-1:0];
      pspan_in = pabs[QUOT_W-1:0];
      pneg0_in = psp[16];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         yang_ff  <= yang_in;
         yspan_ff <= yspan_in;
         yneg0_ff <= yneg0_in;
         pang_ff  <= pang_in;
         pspan_ff <= pspan_in;
         pneg0_ff <= pneg0_in;
      end
      if (en[1]) begin
         yprod_ff <= PROD_W'(yang_ff) * PROD_W'(yspan_ff);
         pprod_ff <= PROD_W'(pang_ff) * PROD_W'(pspan_ff);
         yneg1_ff <= yneg0_ff;
         pneg1_ff <= pneg0_ff;
      end
   end

   // zero limit means a zero product; divide by one keeps the quotient zero
   assign ydiv = (ylim_ff == '0) ? QUOT_W'(1) : ylim_ff;
   assign pdiv = (plim_ff == '0) ? QUOT_W'(1) : plim_ff;

   gasp_div_pipe u_yaw_div (
      .clock    (clock),
      .stage_en (en[DIV_STAGES+1:2]),
      .dividend (yprod_ff),
      .neg_in   (yneg1_ff),
      .divisor  (ydiv),
      .quotient (yquot),
      .neg_out  (yneg2)
   );

   gasp_div_pipe u_pitch_div (
      .clock    (clock),
      .stage_en (en[DIV_STAGES+1:2]),
      .dividend (pprod_ff),
      .neg_in   (pneg1_ff),
      .divisor  (pdiv),
      .quotient (pquot),
      .neg_out  (pneg2)
   );

   function automatic logic [PULSE_W-1:0] sat_pulse(input logic signed [17:0] v);
      logic signed [17:0] s;
      s = v;
      if (s < 18'sd0) begin
         s = 18'sd0;
      end else if (s > PULSE_MAX_S) begin
         s = PULSE_MAX_S;
      end
      return s[PULSE_W-1:0];
   endfunction

   always_comb begin
      logic signed [17:0] yterm, pterm, ybase, pbase;
      logic               pneg;
      yterm = yneg2 ? -$signed({3'b000, yquot}) : $signed({3'b000, yquot});
      ybase = $signed({3'b000, ycen_ff});
      pneg  = pneg2 ^ rev_ff[1];
      pterm = pneg ? -$signed({3'b000, pquot}) : $signed({3'b000, pquot});
      pbase = rev_ff[1] ? $signed({3'b000, pmax_ff}) : $signed({3'b000, pmin_ff});
      ypulse_in = sat_pulse(ybase + yterm);
      ppulse_in = sat_pulse(pbase + pterm);
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         ypulse_ff <= ypulse_in;
         ppulse_ff <= ppulse_in;
      end
   end

   assign rsp_tvalid = valid_ff[S_OUT];
   assign rsp_tdata  = {2'b00, ppulse_ff, ypulse_ff};

   `GASP_ASSERT_NEXT(a_accept_fills, clock, reset, req_tvalid && req_tready, valid_ff[0], "accepted word not captured")
   `GASP_ASSERT(a_full_when_stalled, clock, reset, !req_tready |-> (&valid_ff), "input stalled with a bubble in the pipeline")
   `GASP_ASSERT(a_occupancy, clock, reset, $past(!reset) |-> ($countones(valid_ff) == $countones($past(valid_ff)) + $past(req_tvalid && req_tready) - $past(rsp_tvalid && rsp_tready)), "word lost or duplicated")

endmodule
